// ----- rtl/core/rrc_pkg.sv -----
// shared types, codes and defaults of the rectangle raster canvas
`timescale 1ns / 1ps

package rrc_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int SIZE_W     = 10;
    localparam int CHAR_W     = 8;
    localparam int FIX_W      = 20;
    localparam int RC_W       = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CHAR_W-1:0] BG_RESET   = 8'd32;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } t_state;

    typedef struct packed {
        t_op                      op;
        logic                     fill_mode;
        logic signed [FIX_W-1:0]  rect_left;
        logic signed [FIX_W-1:0]  rect_top;
        logic signed [FIX_W-1:0]  rect_width;
        logic signed [FIX_W-1:0]  rect_height;
        logic [CHAR_W-1:0]        paint_char;
        logic [RC_W-1:0]          read_row;
        logic [RC_W-1:0]          read_col;
    } t_item;

    typedef struct packed {
        logic                     status;
        logic [CHAR_W-1:0]        pixel_char;
    } t_result;

endpackage

// ----- rtl/core/rrc_pixel_class.sv -----
// pixel classifier: inside, border and paint decision for one canvas position
`timescale 1ns / 1ps

module rrc_pixel_class #(
    parameter int AW_R      = 9,
    parameter int AW_C      = 9,
    parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF,
    parameter int PW        = 23
) (
    input  logic [AW_R-1:0]        i_row,
    input  logic [AW_C-1:0]        i_col,
    input  logic                   i_fill,
    input  logic signed [PW-1:0]   i_left,
    input  logic signed [PW-1:0]   i_left_in,
    input  logic signed [PW-1:0]   i_right_in,
    input  logic signed [PW-1:0]   i_right,
    input  logic signed [PW-1:0]   i_top,
    input  logic signed [PW-1:0]   i_top_in,
    input  logic signed [PW-1:0]   i_bottom_in,
    input  logic signed [PW-1:0]   i_bottom,
    output logic                   o_paint
);

    logic signed [PW-1:0] pos_r;
    logic signed [PW-1:0] pos_c;
    logic                 in_rect;
    logic                 border;

    // integer position scaled into the fixed-point domain
    assign pos_r = $signed(PW'(i_row) << FRAC_BITS);
    assign pos_c = $signed(PW'(i_col) << FRAC_BITS);

    assign in_rect = (pos_r >= i_top) && (pos_r <= i_bottom) &&
                     (pos_c >= i_left) && (pos_c <= i_right);

    // less than one unit from an edge
    assign border = (pos_c < i_left_in) || (pos_c > i_right_in) ||
                    (pos_r < i_top_in)  || (pos_r > i_bottom_in);

    assign o_paint = in_rect && (border || i_fill);

endmodule

// ----- rtl/core/rectangle_raster_canvas.sv -----
// top level of the rectangle raster canvas: control, size registers and canvas memory
// usage
//   items enter on i_item when start is high and busy is low; one result beat
//   per item leaves on o_result, marked by o_valid for exactly one cycle
//   op clear: writes the background character to every pixel in use,
//     result beat (status 0) registered after the last pixel is written
//   op draw: scans every pixel in use once and paints border pixels, or
//     border and interior ones in filled mode; same latency as a clear
//   a draw with width or height not positive is rejected: status 1 in the cycle
//     after the start beat, canvas untouched; an unused op code answers alike
//     with status 0
//   op read: result beat after the memory read register, then the output register
//   the scan visits one pixel per cycle through the single write port of the
//   canvas memory; a new item may be started in the cycle that carries the previous
//   result; configuration is to be written through i_cfg_we/i_cfg_idx/i_cfg_data
//   while busy is low, which the block itself does not enforce; sizes are clamped
//   into 1..max, unknown indexes are ignored
//   reset returns the control logic to idle and width 1, height 1, background
//   space; the canvas memory keeps no reset value and must be cleared first
//   the receiver cannot stall: results are never held back
`timescale 1ns / 1ps

module rectangle_raster_canvas #(
    parameter int MAX_WIDTH  = rrc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rrc_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = rrc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rrc_pkg::t_item                      i_item,
    output logic                                o_valid,
    output rrc_pkg::t_result                    o_result,
    input  logic                                i_cfg_we,
    input  logic [rrc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rrc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // address split: row bits above column bits
    localparam int AW_C  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int AW_R  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = 2 ** (AW_R + AW_C);
    localparam int SW    = rrc_pkg::SIZE_W;
    localparam int CW    = rrc_pkg::CHAR_W;
    // compare widths for the scan counters against the size registers
    localparam int CC_W  = ((AW_C > SW) ? AW_C : SW) + 1;
    localparam int CR_W  = ((AW_R > SW) ? AW_R : SW) + 1;
    // fixed-point bound width: covers scaled positions and left+width-unit
    localparam int PA_W  = ((AW_R > AW_C) ? AW_R : AW_C) + FRAC_BITS + 1;
    localparam int PW    = (PA_W > rrc_pkg::FIX_W + 3) ? PA_W : rrc_pkg::FIX_W + 3;
    localparam logic signed [PW-1:0] UNIT = $signed(PW'(1) << FRAC_BITS);

    // control state
    rrc_pkg::t_state   r_state, n_state;
    logic [AW_R-1:0]   r_row, n_row;
    logic [AW_C-1:0]   r_col, n_col;
    logic              r_out_valid, n_out_valid;
    rrc_pkg::t_result  r_out, n_out;

    // configuration registers
    logic [SW-1:0]     r_width;
    logic [SW-1:0]     r_height;
    logic [CW-1:0]     r_bg;
    logic [SW-1:0]     cfg_size;
    logic [SW-1:0]     cfg_width;
    logic [SW-1:0]     cfg_height;

    // item held for the scan or the read
    logic              r_is_clear;
    logic              r_fill;
    logic [CW-1:0]     r_paint;
    logic              r_rd_ok;
    logic signed [PW-1:0] r_left, r_left_in, r_right_in, r_right;
    logic signed [PW-1:0] r_top,  r_top_in,  r_bottom_in, r_bottom;

    // canvas memory
    logic [CW-1:0]     r_canvas [DEPTH];
    logic [CW-1:0]     r_rd_data;
    logic              mem_we;
    logic [CW-1:0]     mem_wdata;
    logic [AW_R+AW_C-1:0] rd_addr;

    logic              accept;
    logic              reject;
    logic              paint;
    logic              last_col;
    logic              last_row;

    assign busy     = (r_state != rrc_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // a draw needs both sizes strictly positive
    assign reject = i_item.rect_width[rrc_pkg::FIX_W-1]  || (i_item.rect_width == '0) ||
                    i_item.rect_height[rrc_pkg::FIX_W-1] || (i_item.rect_height == '0);

    // ---------------- configuration ----------------
    // sizes: zero reads as one, anything above the maximum as the maximum
    assign cfg_size   = (i_cfg_data[SW-1:0] == '0) ? SW'(1) : i_cfg_data[SW-1:0];
    assign cfg_width  = (int'(cfg_size) > MAX_WIDTH)  ? SW'(MAX_WIDTH)  : cfg_size;
    assign cfg_height = (int'(cfg_size) > MAX_HEIGHT) ? SW'(MAX_HEIGHT) : cfg_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rrc_pkg::SIZE_RESET;
            r_height <= rrc_pkg::SIZE_RESET;
            r_bg     <= rrc_pkg::BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rrc_pkg::CFG_CANVAS_WIDTH:  r_width  <= cfg_width;
                rrc_pkg::CFG_CANVAS_HEIGHT: r_height <= cfg_height;
                rrc_pkg::CFG_BACKGROUND:    r_bg     <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- item capture ----------------
    // edges and their one-unit inner bounds are settled once per accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_clear  <= (i_item.op == rrc_pkg::OP_CLEAR);
            r_fill      <= i_item.fill_mode;
            r_paint     <= i_item.paint_char;
            r_rd_ok     <= (SW'(i_item.read_row) < r_height) &&
                           (SW'(i_item.read_col) < r_width);
            r_left      <= PW'(i_item.rect_left);
            r_left_in   <= PW'(i_item.rect_left) + UNIT;
            r_right     <= PW'(i_item.rect_left) + PW'(i_item.rect_width);
            r_right_in  <= PW'(i_item.rect_left) + PW'(i_item.rect_width) - UNIT;
            r_top       <= PW'(i_item.rect_top);
            r_top_in    <= PW'(i_item.rect_top) + UNIT;
            r_bottom    <= PW'(i_item.rect_top) + PW'(i_item.rect_height);
            r_bottom_in <= PW'(i_item.rect_top) + PW'(i_item.rect_height) - UNIT;
        end
    end

    // ---------------- pixel decision ----------------
    rrc_pixel_class #(
        .AW_R      (AW_R),
        .AW_C      (AW_C),
        .FRAC_BITS (FRAC_BITS),
        .PW        (PW)
    ) u_class (
        .i_row       (r_row),
        .i_col       (r_col),
        .i_fill      (r_fill),
        .i_left      (r_left),
        .i_left_in   (r_left_in),
        .i_right_in  (r_right_in),
        .i_right     (r_right),
        .i_top       (r_top),
        .i_top_in    (r_top_in),
        .i_bottom_in (r_bottom_in),
        .i_bottom    (r_bottom),
        .o_paint     (paint)
    );

    assign last_col  = (CC_W'(r_col) == CC_W'(r_width)  - CC_W'(1));
    assign last_row  = (CR_W'(r_row) == CR_W'(r_height) - CR_W'(1));
    assign mem_wdata = r_is_clear ? r_bg : r_paint;

    // read port addressed straight from the item; it reads every cycle, but only
    // a read item started while idle uses the data, so it never meets a scan write
    assign rd_addr = {AW_R'(i_item.read_row), AW_C'(i_item.read_col)};

    // ---------------- canvas memory ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_canvas[{r_row, r_col}] <= mem_wdata;
        end
        r_rd_data <= r_canvas[rd_addr];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrc_pkg::ST_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_out_valid = 1'b0;
        n_out       = r_out;
        mem_we      = 1'b0;
        case (r_state)
            rrc_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_item.op)
                        rrc_pkg::OP_CLEAR: begin
                            n_state = rrc_pkg::ST_SCAN;
                            n_row   = '0;
                            n_col   = '0;
                        end
                        rrc_pkg::OP_DRAW: begin
                            if (reject) begin
                                n_out_valid      = 1'b1;
                                n_out.status     = 1'b1;
                                n_out.pixel_char = '0;
                            end else begin
                                n_state = rrc_pkg::ST_SCAN;
                                n_row   = '0;
                                n_col   = '0;
                            end
                        end
                        rrc_pkg::OP_READ: begin
                            n_state = rrc_pkg::ST_READ;
                        end
                        default: begin
                            n_out_valid      = 1'b1;
                            n_out.status     = 1'b0;
                            n_out.pixel_char = '0;
                        end
                    endcase
                end
            end
            rrc_pkg::ST_SCAN: begin
                // one pixel a cycle, row by row
                mem_we = r_is_clear || paint;
                if (last_col) begin
                    n_col = '0;
                    if (last_row) begin
                        n_state          = rrc_pkg::ST_IDLE;
                        n_out_valid      = 1'b1;
                        n_out.status     = 1'b0;
                        n_out.pixel_char = '0;
                    end else begin
                        n_row = r_row + AW_R'(1);
                    end
                end else begin
                    n_col = r_col + AW_C'(1);
                end
            end
            rrc_pkg::ST_READ: begin
                n_state          = rrc_pkg::ST_IDLE;
                n_out_valid      = 1'b1;
                n_out.status     = 1'b0;
                n_out.pixel_char = r_rd_ok ? r_rd_data : '0;
            end
            default: begin
                n_state = rrc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
